[sv/acfp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ASCII command frame parser package
// Shared constants, payload types and the two-digit decode helper.
// ----------------------------------------------------------------------------
package acfp_pkg;

  localparam int unsigned DEFAULT_BUFFER_DEPTH = 20;

  localparam logic [7:0] START_BYTE = 8'h41;
  localparam logic [7:0] END_BYTE   = 8'h44;
  localparam logic [7:0] ASCII_ZERO = 8'h30;

  // Buffer bytes that the decoder looks at.
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [7:0] b5;
    logic [7:0] b6;
    logic [7:0] b7;
    logic [7:0] b8;
    logic [7:0] b9;
    logic [7:0] b10;
  } frame_fields_t;

  typedef struct packed {
    logic [7:0] command_digit;
    logic [7:0] duration;
    logic [7:0] mark_a;
    logic [7:0] mark_b;
    logic [7:0] mark_c;
  } frame_result_t;

  // (hi - '0') * 10 + (lo - '0'), wrapping in eight bits.
  function automatic logic [7:0] decode_pair(input logic [7:0] hi, input logic [7:0] lo);
    logic [7:0] h;
    logic [7:0] l;
    begin
      h = hi - ASCII_ZERO;
      l = lo - ASCII_ZERO;
      return (h << 3) + (h << 1) + l;
    end
  endfunction

endpackage

[sv/acfp_frame_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame store
// Byte buffer with a saturating write position; 'A' rewinds the position.
// ----------------------------------------------------------------------------
module acfp_frame_store #(
  parameter int unsigned BUFFER_DEPTH = acfp_pkg::DEFAULT_BUFFER_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [7:0]            rx_byte,
  output acfp_pkg::frame_fields_t fields
);

  localparam int unsigned IDX_W = $clog2(BUFFER_DEPTH);
  localparam int unsigned POS_W = $clog2(BUFFER_DEPTH + 1);

  logic [7:0]       buffer [BUFFER_DEPTH];
  logic [POS_W-1:0] position;
  logic             is_start;
  logic             is_data;
  logic             has_room;

  assign is_start = (rx_byte == acfp_pkg::START_BYTE);
  assign is_data  = !is_start && (rx_byte != acfp_pkg::END_BYTE);
  assign has_room = (position < POS_W'(BUFFER_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      for (int i = 0; i < BUFFER_DEPTH; i++) begin
        buffer[i] <= '0;
      end
    end else if (accept) begin
      if (is_start) begin
        position <= '0;
      end else if (is_data && has_room) begin
        buffer[position[IDX_W-1:0]] <= rx_byte;
        position <= position + POS_W'(1);
      end
    end
  end

  assign fields.b0  = buffer[0];
  assign fields.b2  = buffer[2];
  assign fields.b3  = buffer[3];
  assign fields.b5  = buffer[5];
  assign fields.b6  = buffer[6];
  assign fields.b7  = buffer[7];
  assign fields.b8  = buffer[8];
  assign fields.b9  = buffer[9];
  assign fields.b10 = buffer[10];

endmodule

[sv/acfp_decode.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame decoder
// Turns the fixed buffer positions into the command digit and four numbers.
// ----------------------------------------------------------------------------
module acfp_decode (
  input  acfp_pkg::frame_fields_t fields,
  output acfp_pkg::frame_result_t result
);

  assign result.command_digit = fields.b0 - acfp_pkg::ASCII_ZERO;
  assign result.duration      = acfp_pkg::decode_pair(fields.b2, fields.b3);
  assign result.mark_a        = acfp_pkg::decode_pair(fields.b5, fields.b6);
  assign result.mark_b        = acfp_pkg::decode_pair(fields.b7, fields.b8);
  assign result.mark_c        = acfp_pkg::decode_pair(fields.b9, fields.b10);

endmodule

[sv/ascii_command_frame_parser_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ASCII command frame parser
// Buffers received bytes and decodes a command frame on each 'D'.
// ----------------------------------------------------------------------------
// Output: a 'D' request's result is registered and shows in the cycle after it is accepted.
// Throughput: one byte per cycle; the single output register lets a new byte
// in whenever it is empty or being taken in the same cycle.
// Reset: synchronous; clears the buffer to zeros, the write position and the
// output register's valid flag.
module ascii_command_frame_parser_unit #(
  parameter int unsigned BUFFER_DEPTH = acfp_pkg::DEFAULT_BUFFER_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] command_digit,
  output logic [7:0] duration,
  output logic [7:0] mark_a,
  output logic [7:0] mark_b,
  output logic [7:0] mark_c
);

  logic                    accept;
  logic                    is_end;
  acfp_pkg::frame_fields_t fields;
  acfp_pkg::frame_result_t decoded;
  acfp_pkg::frame_result_t result;
  logic                    result_valid;

  // The output register frees up in the same cycle that it is taken.
  assign in_stall = result_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign is_end   = (rx_byte == acfp_pkg::END_BYTE);

  acfp_frame_store #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_store (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .rx_byte(rx_byte),
    .fields (fields)
  );

  acfp_decode u_decode (
    .fields(fields),
    .result(decoded)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept && is_end) begin
      result_valid <= 1'b1;
    end else if (!out_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_end) begin
      result <= decoded;
    end
  end

  assign out_valid     = result_valid;
  assign command_digit = result.command_digit;
  assign duration      = result.duration;
  assign mark_a        = result.mark_a;
  assign mark_b        = result.mark_b;
  assign mark_c        = result.mark_c;

endmodule

[bench/tb_ascii_command_frame_parser_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ASCII command frame parser testbench
// Streams bytes into the parser and checks every decoded command against a
// byte-level software copy of its buffer and write position. The sender
// works in random bursts, and the receiver stalls on its own pattern. Twice,
// the receiver holds off for a long stretch so that the input backs up.
// ----------------------------------------------------------------------------
module tb_ascii_command_frame_parser_unit;

  localparam int unsigned DEPTH = acfp_pkg::DEFAULT_BUFFER_DEPTH;
  localparam int          TOTAL_BYTES = 750;
  localparam int          HOLD_CYCLES = 160;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] command_digit;
  logic [7:0] duration;
  logic [7:0] mark_a;
  logic [7:0] mark_b;
  logic [7:0] mark_c;

  ascii_command_frame_parser_unit #(
    .BUFFER_DEPTH(DEPTH)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .command_digit(command_digit),
    .duration     (duration),
    .mark_a       (mark_a),
    .mark_b       (mark_b),
    .mark_c       (mark_c)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Bytes waiting to be sent and commands waiting to come out.
  logic [7:0]              pending_bytes[$];
  acfp_pkg::frame_result_t expected_frames[$];

  // Software copy of the parser state.
  logic [7:0] frame_mem[DEPTH];
  logic [4:0] fill_pos;

  int fail_count = 0;
  int sent_count = 0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;
  int hold_starts = 0;

  function automatic logic [7:0] decimal_pair(input logic [7:0] hi, input logic [7:0] lo);
    logic [7:0] tens;
    logic [7:0] ones;
    begin
      tens = hi - acfp_pkg::ASCII_ZERO;
      ones = lo - acfp_pkg::ASCII_ZERO;
      return tens * 8'd10 + ones;
    end
  endfunction

  task automatic predict_byte(input logic [7:0] b);
    acfp_pkg::frame_result_t res;
    begin
      if (b == acfp_pkg::START_BYTE) begin
        fill_pos = '0;
      end else if (b == acfp_pkg::END_BYTE) begin
        res.command_digit = frame_mem[0] - acfp_pkg::ASCII_ZERO;
        res.duration      = decimal_pair(frame_mem[2], frame_mem[3]);
        res.mark_a        = decimal_pair(frame_mem[5], frame_mem[6]);
        res.mark_b        = decimal_pair(frame_mem[7], frame_mem[8]);
        res.mark_c        = decimal_pair(frame_mem[9], frame_mem[10]);
        expected_frames.push_back(res);
      end else if (fill_pos < DEPTH) begin
        // Once the buffer is full, data bytes are dropped and the position sticks.
        frame_mem[fill_pos] = b;
        fill_pos = fill_pos + 5'd1;
      end
    end
  endtask

  task automatic push_text(input string s);
    begin
      for (int i = 0; i < s.len(); i++) pending_bytes.push_back(s[i]);
    end
  endtask

  function automatic logic [7:0] data_byte();
    logic [7:0] b;
    begin
      if ($urandom_range(0, 99) < 85) begin
        return acfp_pkg::ASCII_ZERO + 8'($urandom_range(0, 9));
      end
      b = 8'($urandom_range(0, 255));
      while (b == acfp_pkg::START_BYTE || b == acfp_pkg::END_BYTE) begin
        b = 8'($urandom_range(0, 255));
      end
      return b;
    end
  endfunction

  task automatic push_random_frame();
    int kind;
    int len;
    begin
      kind = $urandom_range(0, 9);
      if (kind == 0) len = $urandom_range(0, 10);
      else if (kind == 1) len = $urandom_range(DEPTH - 2, DEPTH + 6);
      else len = $urandom_range(11, 14);
      // Now and then the start byte is missing, so the frame continues the old one.
      if ($urandom_range(0, 7) != 0) pending_bytes.push_back(acfp_pkg::START_BYTE);
      for (int i = 0; i < len; i++) pending_bytes.push_back(data_byte());
      pending_bytes.push_back(acfp_pkg::END_BYTE);
      if ($urandom_range(0, 9) == 0) pending_bytes.push_back(acfp_pkg::END_BYTE);
    end
  endtask

  task automatic push_noise();
    int len;
    begin
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++) pending_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // Driver: one request per accepted byte, sent in bursts with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      rx_byte  <= 8'h00;
      for (int i = 0; i < DEPTH; i++) frame_mem[i] = 8'h00;
      fill_pos = '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_byte(rx_byte);
        sent_count <= sent_count + 1;
      end
      if (in_valid && in_stall) begin
        // Stalled request holds its payload.
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        in_valid <= 1'b1;
        rx_byte  <= pending_bytes.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-offs, started at two points of the input stream.
  always @(posedge clk) begin
    if (rst) begin
      hold_left   <= 0;
      hold_starts <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_starts < 2 && sent_count >= (hold_starts + 1) * 250) begin
      hold_left   <= HOLD_CYCLES;
      hold_starts <= hold_starts + 1;
    end
  end

  // Monitor: compares each accepted command and drives the receiver stall.
  int                      stall_phase = 0;
  logic                    stall_next;
  acfp_pkg::frame_result_t want;

  always @(posedge clk) begin
    if (rst) begin
      out_stall   <= 1'b0;
      stall_phase = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_frames.size() == 0) begin
          $error("unexpected result: command_digit %0d", command_digit);
          fail_count++;
        end else begin
          want = expected_frames.pop_front();
          if (command_digit !== want.command_digit) begin
            $error("command_digit: expected %0d, got %0d", want.command_digit, command_digit);
            fail_count++;
          end
          if (duration !== want.duration) begin
            $error("duration: expected %0d, got %0d", want.duration, duration);
            fail_count++;
          end
          if (mark_a !== want.mark_a) begin
            $error("mark_a: expected %0d, got %0d", want.mark_a, mark_a);
            fail_count++;
          end
          if (mark_b !== want.mark_b) begin
            $error("mark_b: expected %0d, got %0d", want.mark_b, mark_b);
            fail_count++;
          end
          if (mark_c !== want.mark_c) begin
            $error("mark_c: expected %0d, got %0d", want.mark_c, mark_c);
            fail_count++;
          end
        end
      end
      // The stall pattern rotates through phases: none, periodic, heavy, light.
      stall_phase++;
      unique case ((stall_phase / 64) % 4)
        0: stall_next = 1'b0;
        1: stall_next = (stall_phase % 3) == 0;
        2: stall_next = $urandom_range(0, 1) == 1;
        default: stall_next = $urandom_range(0, 3) == 0;
      endcase
      out_stall <= stall_next || (hold_left > 0);
    end
  end

  initial begin
    // Command decoded from a buffer that was never written.
    pending_bytes.push_back(acfp_pkg::END_BYTE);
    // Full frame with the largest and smallest two-digit values.
    pending_bytes.push_back(acfp_pkg::START_BYTE);
    push_text("9,99,00999900");
    pending_bytes.push_back(acfp_pkg::END_BYTE);
    // Extreme non-digit bytes overwrite the head of the old frame.
    pending_bytes.push_back(acfp_pkg::START_BYTE);
    pending_bytes.push_back(8'hFF);
    pending_bytes.push_back(8'h00);
    pending_bytes.push_back(acfp_pkg::END_BYTE);
    // Repeated start only rewinds; old contents still decode.
    pending_bytes.push_back(acfp_pkg::START_BYTE);
    pending_bytes.push_back(acfp_pkg::START_BYTE);
    pending_bytes.push_back(acfp_pkg::END_BYTE);

    while (pending_bytes.size() < TOTAL_BYTES) begin
      if ($urandom_range(0, 4) == 0) push_noise();
      else push_random_frame();
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (pending_bytes.size() > 0 || in_valid || expected_frames.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);

    if (fail_count == 0) begin
      $display("tb_ascii_command_frame_parser_unit passed");
    end else begin
      $display("tb_ascii_command_frame_parser_unit failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_ascii_command_frame_parser_unit failed");
    $finish;
  end

endmodule
